// File: hw/rtl/fcr_pkg.sv
`timescale 1ns / 1ps

package fcr_pkg;

   // Frame layout constants
   localparam int MAX_DATA_BYTES_DEF = 16;
   localparam int FIXED_BYTES        = 5;

   // Register reset values
   localparam logic [7:0] HEADER_RESET = 8'h7E;
   localparam logic [7:0] TAIL_RESET   = 8'h81;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_IDX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_IDX   = 1'b1;

   // Request codes carried in data bytes 1 and 2
   localparam logic [1:0] CODE_NONE = 2'd0;
   localparam logic [1:0] CODE_ONE  = 2'd1;
   localparam logic [1:0] CODE_TWO  = 2'd2;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LENGTH = 3'd1,
      PH_FUNC   = 3'd2,
      PH_DATA   = 3'd3,
      PH_CHECK  = 3'd4,
      PH_TAIL   = 3'd5
   } phase_type;

   // Map a data byte to a request code: only one and two mean anything
   function automatic logic [1:0] decode_code(input logic [7:0] v);
      logic [1:0] code;
      code = CODE_NONE;
      if (v == {6'd0, CODE_ONE}) begin
         code = CODE_ONE;
      end else if (v == {6'd0, CODE_TWO}) begin
         code = CODE_TWO;
      end
      return code;
   endfunction

endpackage

// File: hw/rtl/framed_command_receiver_top.sv
`timescale 1ns / 1ps

// Framed command receiver. Takes one link byte per beat, one beat every clock
// cycle unless stalled, and hunts for frames of header, length, function,
// data, check and tail bytes; the length byte counts the whole frame, and the
// check is the complemented XOR of header through last data byte. A good
// frame's result appears on the rsp_ port in the cycle after its tail byte is
// accepted and is held in an output register, so req_stall rises only while
// that register is full and stalled. Header and tail values are set through
// the csr_ port; the user must do so only while idle; it is not enforced.
module framed_command_receiver_top #(
   parameter int MAX_DATA_BYTES = fcr_pkg::MAX_DATA_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_function_code,
   output logic [1:0]                    rsp_calibration_axis,
   output logic [1:0]                    rsp_mode_request,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);

   localparam int CNT_W = $clog2(MAX_DATA_BYTES);
   localparam logic [8:0] LEN_LIMIT = 9'(MAX_DATA_BYTES + fcr_pkg::FIXED_BYTES);
   localparam logic [7:0] LEN_FIXED = 8'(fcr_pkg::FIXED_BYTES);

   fcr_pkg::phase_type phase_ff, phase_in;

   logic [7:0]       header_ff, tail_ff;
   logic [7:0]       check_ff, check_in;
   logic [CNT_W-1:0] data_len_ff, data_len_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       func_ff, func_in;
   logic [7:0]       byte_one_ff, byte_one_in;
   logic [7:0]       byte_two_ff, byte_two_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_func_ff, rsp_func_in;
   logic [1:0]       rsp_axis_ff, rsp_axis_in;
   logic [1:0]       rsp_mode_ff, rsp_mode_in;

   logic             accept;
   logic             out_free;
   logic             len_ok;
   logic [CNT_W-1:0] count_inc;
   logic [7:0]       len_less_fixed;

   // handshake: the output register parts the two sides
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;
   assign csr_ready = 1'b1;

   assign len_ok         = ({1'b0, req_rx_byte} < LEN_LIMIT) && (req_rx_byte > LEN_FIXED);
   assign len_less_fixed = req_rx_byte - LEN_FIXED;
   assign count_inc      = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};

   // next state and result
   always_comb begin
      phase_in     = phase_ff;
      check_in     = check_ff;
      data_len_in  = data_len_ff;
      count_in     = count_ff;
      func_in      = func_ff;
      byte_one_in  = byte_one_ff;
      byte_two_in  = byte_two_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_func_in  = rsp_func_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_mode_in  = rsp_mode_ff;
      if (accept) begin
         case (phase_ff)
            fcr_pkg::PH_LENGTH: begin
               if (len_ok) begin
                  data_len_in = len_less_fixed[CNT_W-1:0];
                  check_in    = check_ff ^ req_rx_byte;
                  phase_in    = fcr_pkg::PH_FUNC;
               end else begin
                  phase_in = fcr_pkg::PH_HEADER;
               end
            end
            fcr_pkg::PH_FUNC: begin
               func_in  = req_rx_byte;
               check_in = check_ff ^ req_rx_byte;
               count_in = '0;
               phase_in = fcr_pkg::PH_DATA;
            end
            fcr_pkg::PH_DATA: begin
               if (count_ff == CNT_W'(1)) begin
                  byte_one_in = req_rx_byte;
               end else if (count_ff == CNT_W'(2)) begin
                  byte_two_in = req_rx_byte;
               end
               check_in = check_ff ^ req_rx_byte;
               count_in = count_inc;
               if (count_inc >= data_len_ff) begin
                  phase_in = fcr_pkg::PH_CHECK;
               end
            end
            fcr_pkg::PH_CHECK: begin
               phase_in = (req_rx_byte == ~check_ff) ? fcr_pkg::PH_TAIL
                                                     : fcr_pkg::PH_HEADER;
            end
            fcr_pkg::PH_TAIL: begin
               if (req_rx_byte == tail_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_func_in  = func_ff;
                  rsp_axis_in  = fcr_pkg::decode_code(byte_one_ff);
                  rsp_mode_in  = fcr_pkg::decode_code(byte_two_ff);
               end
               phase_in = fcr_pkg::PH_HEADER;
            end
            default: begin
               // hunting for a header, also covers unused codes
               if (req_rx_byte == header_ff) begin
                  check_in = req_rx_byte;
                  phase_in = fcr_pkg::PH_LENGTH;
               end else begin
                  phase_in = fcr_pkg::PH_HEADER;
               end
            end
         endcase
      end
   end

   // control state and kept data bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fcr_pkg::PH_HEADER;
         rsp_valid_ff <= 1'b0;
         byte_one_ff  <= '0;
         byte_two_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         byte_one_ff  <= byte_one_in;
         byte_two_ff  <= byte_two_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      check_ff    <= check_in;
      data_len_ff <= data_len_in;
      count_ff    <= count_in;
      func_ff     <= func_in;
      rsp_func_ff <= rsp_func_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= fcr_pkg::HEADER_RESET;
         tail_ff   <= fcr_pkg::TAIL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fcr_pkg::CSR_HEADER_IDX: header_ff <= csr_data;
            fcr_pkg::CSR_TAIL_IDX:   tail_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_function_code    = rsp_func_ff;
   assign rsp_calibration_axis = rsp_axis_ff;
   assign rsp_mode_request     = rsp_mode_ff;

endmodule

// File: hw/rtl/fcr_checker.sv
`timescale 1ns / 1ps

module fcr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [7:0]                    req_rx_byte,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [7:0]                    rsp_function_code,
   input logic [1:0]                    rsp_calibration_axis,
   input logic [1:0]                    rsp_mode_request,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [fcr_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [7:0]                    csr_data
);

   // input only backs up behind a full, stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held result");

   // a new result follows an accepted byte
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result appeared without an accepted byte");

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_function_code)
         && $stable(rsp_calibration_axis) && $stable(rsp_mode_request)))
      else $error("stalled result changed");

   // decoded codes never take the unused value
   a_codes_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_calibration_axis != 2'd3) && (rsp_mode_request != 2'd3)))
      else $error("illegal request code on result");

endmodule

bind framed_command_receiver_top fcr_checker u_fcr_checker (.*);

// File: tb/framed_command_receiver_top_tb.sv
`timescale 1ns / 1ps

module framed_command_receiver_top_tb;

   localparam int MAX_DATA    = fcr_pkg::MAX_DATA_BYTES_DEF;
   localparam int FIXED_BYTES = fcr_pkg::FIXED_BYTES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [7:0] func;
      logic [1:0] axis;
      logic [1:0] mode;
   } command_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CHECK,
      FRAME_BAD_TAIL
   } frame_fault_type;

   logic       clock;
   logic       reset;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic [7:0] rsp_function_code;
   logic [1:0] rsp_calibration_axis;
   logic [1:0] rsp_mode_request;
   logic       csr_valid;
   logic       csr_ready;
   logic [fcr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [7:0] csr_data;

   // Stimulus and scoreboard storage
   logic [7:0]  pending_bytes[$];
   command_type expected_cmds[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          bytes_queued;

   // Idling knobs and the long receiver hold-off
   int         send_idle_pct = 15;
   int         recv_idle_pct = 79;
   logic       hold_start = 1'b0;
   int         hold_left = 0;

   // Predictor copy of the registers and parser state
   logic [7:0]         cfg_header;
   logic [7:0]         cfg_tail;
   fcr_pkg::phase_type rx_phase;
   logic [7:0]         rx_check;
   logic [7:0]         rx_length;
   int                 rx_count;
   logic [7:0]         rx_func;
   logic [7:0]         rx_data_one;
   logic [7:0]         rx_data_two;

   framed_command_receiver_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_function_code   (rsp_function_code),
      .rsp_calibration_axis(rsp_calibration_axis),
      .rsp_mode_request    (rsp_mode_request),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the frame parser by one byte; flags a command on a good tail
   function automatic void parse_byte(input logic [7:0] b, output logic fired,
                                      output command_type cmd);
      fired = 1'b0;
      cmd   = '0;
      case (rx_phase)
         fcr_pkg::PH_LENGTH: begin
            if (b < MAX_DATA + FIXED_BYTES && b > FIXED_BYTES) begin
               rx_length = b;
               rx_check  = rx_check ^ b;
               rx_phase  = fcr_pkg::PH_FUNC;
            end else begin
               rx_phase = fcr_pkg::PH_HEADER;
            end
         end
         fcr_pkg::PH_FUNC: begin
            rx_func  = b;
            rx_check = rx_check ^ b;
            rx_count = 0;
            rx_phase = fcr_pkg::PH_DATA;
         end
         fcr_pkg::PH_DATA: begin
            if (rx_count == 1) begin
               rx_data_one = b;
            end else if (rx_count == 2) begin
               rx_data_two = b;
            end
            rx_check = rx_check ^ b;
            rx_count = rx_count + 1;
            if (rx_count >= int'(rx_length) - FIXED_BYTES) begin
               rx_phase = fcr_pkg::PH_CHECK;
            end
         end
         fcr_pkg::PH_CHECK: begin
            rx_check = ~rx_check;
            rx_phase = (b == rx_check) ? fcr_pkg::PH_TAIL : fcr_pkg::PH_HEADER;
         end
         fcr_pkg::PH_TAIL: begin
            if (b == cfg_tail) begin
               fired    = 1'b1;
               cmd.func = rx_func;
               cmd.axis = (rx_data_one == 8'd1) ? fcr_pkg::CODE_ONE :
                          (rx_data_one == 8'd2) ? fcr_pkg::CODE_TWO : fcr_pkg::CODE_NONE;
               cmd.mode = (rx_data_two == 8'd1) ? fcr_pkg::CODE_ONE :
                          (rx_data_two == 8'd2) ? fcr_pkg::CODE_TWO : fcr_pkg::CODE_NONE;
            end
            rx_phase = fcr_pkg::PH_HEADER;
         end
         default: begin
            if (b == cfg_header) begin
               rx_check = b;
               rx_phase = fcr_pkg::PH_LENGTH;
            end else begin
               rx_phase = fcr_pkg::PH_HEADER;
            end
         end
      endcase
   endfunction

   // Byte driver: moves to the next beat only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus the occasional long hold-off
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= hold_start || hold_left > 1 || $urandom_range(0, 99) < recv_idle_pct;
   end

   // Monitor: check result beats, then predict from accepted byte beats
   always @(posedge clock) begin
      command_type got;
      command_type want;
      command_type cmd;
      logic        fired;
      if (reset) begin
         cfg_header  = fcr_pkg::HEADER_RESET;
         cfg_tail    = fcr_pkg::TAIL_RESET;
         rx_phase    = fcr_pkg::PH_HEADER;
         rx_check    = 8'h00;
         rx_length   = 8'h00;
         rx_count    = 0;
         rx_func     = 8'h00;
         rx_data_one = 8'h00;
         rx_data_two = 8'h00;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_function_code, rsp_calibration_axis, rsp_mode_request};
            if (expected_cmds.size() == 0) begin
               $display("%0t: result expected none got func=%02h axis=%0d mode=%0d",
                        $time, got.func, got.axis, got.mode);
               error_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (got.func !== want.func) begin
                  $display("%0t: function_code expected %02h got %02h",
                           $time, want.func, got.func);
                  error_count++;
               end
               if (got.axis !== want.axis) begin
                  $display("%0t: calibration_axis expected %0d got %0d",
                           $time, want.axis, got.axis);
                  error_count++;
               end
               if (got.mode !== want.mode) begin
                  $display("%0t: mode_request expected %0d got %0d",
                           $time, want.mode, got.mode);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte, fired, cmd);
            if (fired) begin
               expected_cmds.push_back(cmd);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Build one frame at the current header/tail; cut > 0 truncates it
   task automatic queue_frame(input int len, input logic [7:0] func,
                              input logic [7:0] d1, input logic [7:0] d2,
                              input frame_fault_type fault, input int cut);
      logic [7:0] frame[$];
      logic [7:0] sum;
      logic [7:0] d;
      int         i;
      frame.push_back(cfg_header);
      frame.push_back(len[7:0]);
      frame.push_back(func);
      sum = cfg_header ^ len[7:0] ^ func;
      for (i = 0; i < len - FIXED_BYTES; i++) begin
         d = (i == 1) ? d1 : (i == 2) ? d2 : 8'($urandom);
         frame.push_back(d);
         sum = sum ^ d;
      end
      if (fault == FRAME_BAD_CHECK) begin
         frame.push_back(~sum ^ 8'($urandom_range(1, 255)));
      end else begin
         frame.push_back(~sum);
      end
      if (fault == FRAME_BAD_TAIL) begin
         frame.push_back(cfg_tail ^ 8'($urandom_range(1, 255)));
      end else begin
         frame.push_back(cfg_tail);
      end
      if (cut > 0) begin
         frame = frame[0:cut-1];
      end
      foreach (frame[k]) begin
         push_byte(frame[k]);
      end
   endtask

   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd3;
         4: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly good frames of random content, the rest broken or noise
   task automatic queue_random_traffic(input int nbytes);
      int len;
      int r;
      int n;
      bytes_queued = 0;
      while (bytes_queued < nbytes) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = $urandom_range(0, 99);
         end
         len = (r % 20 == 0) ? MAX_DATA + FIXED_BYTES - 1 :
               ($urandom_range(0, 3) != 0) ? $urandom_range(FIXED_BYTES + 1, FIXED_BYTES + 3) :
               $urandom_range(FIXED_BYTES + 1, MAX_DATA + FIXED_BYTES - 1);
         if (r < 70) begin
            queue_frame(len, 8'($urandom), pick_data_byte(), pick_data_byte(), FRAME_GOOD, 0);
         end else if (r < 78) begin
            queue_frame(len, 8'($urandom), pick_data_byte(), pick_data_byte(),
                        FRAME_BAD_CHECK, 0);
         end else if (r < 85) begin
            queue_frame(len, 8'($urandom), pick_data_byte(), pick_data_byte(),
                        FRAME_BAD_TAIL, 0);
         end else if (r < 90) begin
            // out-of-range length byte
            push_byte(cfg_header);
            if ($urandom_range(0, 1) != 0) begin
               push_byte(8'($urandom_range(0, FIXED_BYTES)));
            end else begin
               push_byte(8'($urandom_range(MAX_DATA + FIXED_BYTES, 255)));
            end
         end else if (r < 95) begin
            n = $urandom_range(1, 3);
            repeat (n) push_byte(8'($urandom));
         end else begin
            queue_frame(len, 8'($urandom), pick_data_byte(), pick_data_byte(), FRAME_GOOD,
                        $urandom_range(2, len - 1));
         end
      end
   endtask

   // Register write over the csr channel; predictor copy follows the beat
   task automatic write_reg(input logic [fcr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fcr_pkg::CSR_HEADER_IDX) begin
         cfg_header = val;
      end else begin
         cfg_tail = val;
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_cmds.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = fcr_pkg::CSR_HEADER_IDX;
      csr_data  = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_reg(fcr_pkg::CSR_HEADER_IDX, fcr_pkg::HEADER_RESET);
      write_reg(fcr_pkg::CSR_TAIL_IDX, fcr_pkg::TAIL_RESET);

      // Directed: length limits, field extremes, short frame, bad check and tail
      push_byte(cfg_header);
      push_byte(8'(MAX_DATA + FIXED_BYTES));
      push_byte(cfg_header);
      push_byte(8'(FIXED_BYTES));
      push_byte(cfg_header);
      push_byte(cfg_header);
      queue_frame(FIXED_BYTES + 1, 8'hFF, 8'h00, 8'h00, FRAME_GOOD, 0);
      queue_frame(FIXED_BYTES + 3, 8'h00, 8'd1, 8'd2, FRAME_GOOD, 0);
      queue_frame(FIXED_BYTES + 1, 8'hA5, 8'h00, 8'h00, FRAME_BAD_CHECK, 0);
      queue_frame(FIXED_BYTES + 2, 8'h5A, 8'd2, 8'h00, FRAME_BAD_TAIL, 0);
      queue_frame(FIXED_BYTES + 1, 8'h3C, 8'h00, 8'h00, FRAME_GOOD, 0);
      wait_drained();

      // Long receiver hold-off while short frames keep arriving
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (16) queue_frame(FIXED_BYTES + 1, 8'($urandom), 8'h00, 8'h00, FRAME_GOOD, 0);
      wait_drained();

      queue_random_traffic(266);
      wait_drained();

      // Swap idling sides, extreme register values
      write_reg(fcr_pkg::CSR_HEADER_IDX, 8'h00);
      write_reg(fcr_pkg::CSR_TAIL_IDX, 8'hFF);
      @(posedge clock);
      send_idle_pct <= 79;
      recv_idle_pct <= 15;
      queue_random_traffic(266);
      wait_drained();

      write_reg(fcr_pkg::CSR_HEADER_IDX, 8'hFF);
      write_reg(fcr_pkg::CSR_TAIL_IDX, 8'h00);
      @(posedge clock);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      queue_random_traffic(266);
      wait_drained();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
